[sv/ckhc_pkg.sv]
// shared constants, types and helpers of the canonical k-mer counter
`timescale 1ns / 1ps
package ckhc_pkg;
    localparam int TABLE_BITS  = 12;
    localparam int SLOTS       = 1 << TABLE_BITS;
    localparam int KMER_W      = 62;
    localparam int COUNT_W     = 32;
    localparam int SLOT_OUT_W  = 12;
    localparam int DIST_W      = 13;
    localparam int K_W         = 5;
    localparam int MIX_W       = 3;
    localparam logic [K_W-1:0]     K_RESET   = 5'd15;
    localparam logic [K_W-1:0]     RUN_MAX   = 5'd31;
    localparam logic [31:0]        FIB_MULT  = 32'd2654435769;
    localparam logic [DIST_W-1:0]  DIST_MAX  = 13'd8191;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [MIX_W-1:0]   MIX_LAST  = 3'd6;
    localparam logic [2:0]         CODE_BAD  = 3'd4;

    typedef struct packed {
        logic             load;
        logic             chk;
        logic             mix;
        logic [MIX_W-1:0] mix_sel;
        logic             fib;
        logic             cmp;
        logic             clr;
    } t_cmd;

    typedef struct packed {
        logic have;
        logic clr_last;
        logic empty;
        logic match;
        logic wrap;
    } t_sts;

    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] c;
        case (ch)
            "A", "a": c = 3'd0;
            "C", "c": c = 3'd1;
            "G", "g": c = 3'd2;
            "T", "t": c = 3'd3;
            default:  c = CODE_BAD;
        endcase
        return c;
    endfunction
endpackage

[sv/canonical_kmer_hash_counter_top.sv]
// top level of the canonical k-mer counter with linear-probe count table
//
// channel   direction  handshake               payload
// input     in         start & !busy           i_base_char, i_read_start
// result    out        o_valid (one cycle)     o_kmer_value .. o_distinct_total
// config    in         i_cfg_we                i_cfg_wdata (k)
//
// an item with no k-mer gives no result; a counted k-mer is hashed one shift-add or
// shift-xor step a cycle, then probed slot by slot, each probe one read and one compare
// on the single-port count and key tables.
// after reset all 4096 slots of the count table are cleared, with busy high.
// reset is synchronous, active low; the receiver cannot stall results.
`timescale 1ns / 1ps
module canonical_kmer_hash_counter_top import ckhc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [7:0]            i_base_char,
    input  logic                  i_read_start,
    input  logic                  i_cfg_we,
    input  logic [K_W-1:0]        i_cfg_wdata,
    output logic                  o_valid,
    output logic [KMER_W-1:0]     o_kmer_value,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    output logic [COUNT_W-1:0]    o_kmer_count,
    output logic                  o_is_new,
    output logic                  o_table_full,
    output logic [DIST_W-1:0]     o_distinct_total
);
    t_cmd cmd;
    t_sts sts;

    ckhc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    ckhc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_base_char(i_base_char), .i_read_start(i_read_start),
        .o_valid(o_valid), .o_kmer_value(o_kmer_value),
        .o_slot_index(o_slot_index), .o_kmer_count(o_kmer_count),
        .o_is_new(o_is_new), .o_table_full(o_table_full),
        .o_distinct_total(o_distinct_total)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted transaction did not raise busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without preceding work");

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new && o_table_full)) else $error("new and full together");

    a_new_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_new |-> o_kmer_count == 32'd1) else $error("new slot count not one");
endmodule

[sv/ckhc_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
module ckhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/ckhc_ctrl.sv]
// controller state machine: clear pass, hashing sequence and probe loop
`timescale 1ns / 1ps
module ckhc_ctrl import ckhc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_CHK, S_MIX, S_FIB, S_RD, S_CMP
    } t_state;

    t_state           r_state, n_state;
    logic [MIX_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.mix_sel = r_step;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_step = '0;
                n_state = i_sts.have ? S_MIX : S_IDLE;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == MIX_LAST) n_state = S_FIB;
            end
            S_FIB: begin
                o_cmd.fib = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.empty || i_sts.match || i_sts.wrap) n_state = S_IDLE;
                else n_state = S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

[sv/ckhc_dp.sv]
// datapath: rolling k-mers, hash, probe tables and result registers
`timescale 1ns / 1ps
module ckhc_dp import ckhc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [K_W-1:0]        i_cfg_wdata,
    input  logic [7:0]            i_base_char,
    input  logic                  i_read_start,
    output logic                  o_valid,
    output logic [KMER_W-1:0]     o_kmer_value,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    output logic [COUNT_W-1:0]    o_kmer_count,
    output logic                  o_is_new,
    output logic                  o_table_full,
    output logic [DIST_W-1:0]     o_distinct_total
);
    logic [K_W-1:0]        r_k;
    logic [KMER_W-1:0]     r_fwd, r_rev, r_canon;
    logic [K_W-1:0]        r_run;
    logic                  r_have;
    logic [63:0]           r_v;
    logic [TABLE_BITS-1:0] r_start, r_idx, r_clr;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_valid;
    logic [KMER_W-1:0]     r_o_kmer;
    logic [SLOT_OUT_W-1:0] r_o_slot;
    logic [COUNT_W-1:0]    r_o_cnt;
    logic                  r_o_new, r_o_full;
    logic [DIST_W-1:0]     r_o_dist;

    logic [K_W-1:0]        k_eff;
    logic [KMER_W-1:0]     mask, fwd_src, rev_src, n_fwd, n_rev, ins, canon;
    logic [5:0]            ins_sh;
    logic [2:0]            code;
    logic [K_W-1:0]        run_src, n_run;
    logic [63:0]           mix_v;
    logic [31:0]           prod;
    logic [TABLE_BITS-1:0] idx_next, ram_addr;
    logic [COUNT_W-1:0]    cnt_rdata, cnt_wdata, cnt_inc;
    logic [KMER_W-1:0]     key_rdata;
    logic                  cnt_we, key_we;
    logic [DIST_W-1:0]     dist_inc;

    // rolling update of both strands
    always_comb begin
        k_eff = (r_k == '0) ? 5'd1 : r_k;
        for (int b = 0; b < KMER_W; b++) begin
            mask[b] = (b < 2 * int'(k_eff));
        end
        code    = base_code(i_base_char);
        fwd_src = i_read_start ? '0 : r_fwd;
        rev_src = i_read_start ? '0 : r_rev;
        run_src = i_read_start ? '0 : r_run;
        ins_sh  = {k_eff - 5'd1, 1'b0};
        ins     = KMER_W'(2'd3 - code[1:0]) << ins_sh;
        n_fwd   = ({fwd_src[KMER_W-3:0], code[1:0]}) & mask;
        n_rev   = ((rev_src >> 2) | ins) & mask;
        n_run   = (run_src == RUN_MAX) ? RUN_MAX : run_src + 5'd1;
        canon   = (r_fwd < r_rev) ? r_fwd : r_rev;
    end

    // one shift-add or shift-xor step of the integer hash per cycle
    always_comb begin
        case (i_cmd.mix_sel)
            3'd0:    mix_v = ~r_v + (r_v << 21);
            3'd1:    mix_v = r_v ^ (r_v >> 24);
            3'd2:    mix_v = r_v + (r_v << 3) + (r_v << 8);
            3'd3:    mix_v = r_v ^ (r_v >> 14);
            3'd4:    mix_v = r_v + (r_v << 2) + (r_v << 4);
            3'd5:    mix_v = r_v ^ (r_v >> 28);
            3'd6:    mix_v = r_v + (r_v << 31);
            default: mix_v = r_v;
        endcase
    end

    assign prod = r_v[31:0] * FIB_MULT;

    ckhc_ram #(.WIDTH(COUNT_W), .DEPTH(SLOTS)) u_cnt_ram (
        .i_clk(i_clk), .i_we(cnt_we), .i_addr(ram_addr),
        .i_wdata(cnt_wdata), .o_rdata(cnt_rdata)
    );

    ckhc_ram #(.WIDTH(KMER_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_addr(r_idx),
        .i_wdata(r_canon), .o_rdata(key_rdata)
    );

    always_comb begin
        o_sts.have     = r_have;
        o_sts.clr_last = (r_clr == {TABLE_BITS{1'b1}});
        o_sts.empty    = (cnt_rdata == '0);
        o_sts.match    = !o_sts.empty && (key_rdata == r_canon);
        idx_next       = r_idx + 1'b1;
        o_sts.wrap     = (idx_next == r_start);
        cnt_inc        = (cnt_rdata == COUNT_MAX) ? COUNT_MAX : cnt_rdata + 1'b1;
        dist_inc       = (r_dist == DIST_MAX) ? DIST_MAX : r_dist + 1'b1;
        ram_addr       = i_cmd.clr ? r_clr : r_idx;
        key_we         = i_cmd.cmp && o_sts.empty;
        cnt_we         = i_cmd.clr || (i_cmd.cmp && (o_sts.empty || o_sts.match));
        if (i_cmd.clr)        cnt_wdata = '0;
        else if (o_sts.empty) cnt_wdata = COUNT_W'(1);
        else                  cnt_wdata = cnt_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= K_RESET;
            r_fwd   <= '0;
            r_rev   <= '0;
            r_run   <= '0;
            r_have  <= 1'b0;
            r_clr   <= '0;
            r_dist  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) r_k <= i_cfg_wdata;
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.load) begin
                if (code == CODE_BAD) begin
                    r_fwd  <= '0;
                    r_rev  <= '0;
                    r_run  <= '0;
                    r_have <= 1'b0;
                end else begin
                    r_fwd  <= n_fwd;
                    r_rev  <= n_rev;
                    r_run  <= n_run;
                    r_have <= (n_run >= k_eff);
                end
            end
            if (i_cmd.cmp) begin
                if (o_sts.empty) begin
                    r_dist  <= dist_inc;
                    r_valid <= 1'b1;
                end else if (o_sts.match || o_sts.wrap) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_canon <= canon;
            r_v     <= 64'(canon);
        end
        if (i_cmd.mix) r_v <= mix_v;
        if (i_cmd.fib) begin
            r_start <= prod[31 -: TABLE_BITS];
            r_idx   <= prod[31 -: TABLE_BITS];
        end
        if (i_cmd.cmp) begin
            r_o_kmer <= r_canon;
            r_o_slot <= SLOT_OUT_W'(r_idx);
            r_o_new  <= o_sts.empty;
            r_o_full <= 1'b0;
            r_o_dist <= o_sts.empty ? dist_inc : r_dist;
            if (o_sts.empty) begin
                r_o_cnt <= COUNT_W'(1);
            end else if (o_sts.match) begin
                r_o_cnt <= cnt_inc;
            end else begin
                r_o_cnt  <= '0;
                r_o_full <= 1'b1;
                r_o_slot <= SLOT_OUT_W'(r_start);
                r_idx    <= idx_next;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_kmer_value     = r_o_kmer;
    assign o_slot_index     = r_o_slot;
    assign o_kmer_count     = r_o_cnt;
    assign o_is_new         = r_o_new;
    assign o_table_full     = r_o_full;
    assign o_distinct_total = r_o_dist;
endmodule

[sim/tb_canonical_kmer_hash_counter_top.sv]
// testbench for the canonical k-mer counter: directed and random bases checked against a predictor
`timescale 1ns / 1ps
module tb_canonical_kmer_hash_counter_top;
    import ckhc_pkg::*;

    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [KMER_W-1:0]     kmer;
        logic [SLOT_OUT_W-1:0] slot;
        logic [COUNT_W-1:0]    count;
        logic                  is_new;
        logic                  full;
        logic [DIST_W-1:0]     distinct;
    } t_count_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [7:0]            i_base_char;
    logic                  i_read_start;
    logic                  i_cfg_we;
    logic [K_W-1:0]        i_cfg_wdata;
    logic                  o_valid;
    logic [KMER_W-1:0]     o_kmer_value;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic [COUNT_W-1:0]    o_kmer_count;
    logic                  o_is_new;
    logic                  o_table_full;
    logic [DIST_W-1:0]     o_distinct_total;

    // predictor state
    logic [K_W-1:0]     k_reg;
    logic [63:0]        fwd_kmer;
    logic [63:0]        rev_kmer;
    logic [4:0]         run_len;
    logic [KMER_W-1:0]  key_mem [SLOTS];
    logic [COUNT_W-1:0] count_mem [SLOTS];
    logic [DIST_W-1:0]  distinct_seen;

    t_count_result pending_counts[$];
    int            errors;
    int            idle_pct;
    int            stall_cycles;

    canonical_kmer_hash_counter_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_base_char      (i_base_char),
        .i_read_start     (i_read_start),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_kmer_value     (o_kmer_value),
        .o_slot_index     (o_slot_index),
        .o_kmer_count     (o_kmer_count),
        .o_is_new         (o_is_new),
        .o_table_full     (o_table_full),
        .o_distinct_total (o_distinct_total)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] hash_kmer(input logic [63:0] key);
        logic [63:0] v;
        v = ~key + (key << 21);
        v = v ^ (v >> 24);
        v = (v + (v << 3)) + (v << 8);
        v = v ^ (v >> 14);
        v = (v + (v << 2)) + (v << 4);
        v = v ^ (v >> 28);
        v = v + (v << 31);
        return v[31:0];
    endfunction

    function automatic logic [2:0] char_code(input logic [7:0] ch);
        case (ch)
            8'h41, 8'h61: return 3'd0;
            8'h43, 8'h63: return 3'd1;
            8'h47, 8'h67: return 3'd2;
            8'h54, 8'h74: return 3'd3;
            default:      return CODE_BAD;
        endcase
    endfunction

    task automatic predict_count(input logic [7:0] ch, input logic rs);
        int unsigned   k;
        logic [2:0]    code;
        logic [63:0]   mask;
        logic [63:0]   canon;
        logic [31:0]   prod;
        int unsigned   first;
        int unsigned   idx;
        t_count_result r;
        k = (k_reg == 0) ? 1 : k_reg;
        mask = (64'd1 << (2 * k)) - 64'd1;
        if (rs) begin
            fwd_kmer = 0;
            rev_kmer = 0;
            run_len = 0;
        end
        code = char_code(ch);
        if (code == CODE_BAD) begin
            fwd_kmer = 0;
            rev_kmer = 0;
            run_len = 0;
            return;
        end
        fwd_kmer = ((fwd_kmer << 2) | 64'(code)) & mask;
        rev_kmer = ((rev_kmer >> 2) | (64'(3 - code) << (2 * (k - 1)))) & mask;
        if (run_len < RUN_MAX) run_len = run_len + 1;
        if (run_len < k) return;
        canon = (fwd_kmer < rev_kmer) ? fwd_kmer : rev_kmer;
        prod = hash_kmer(canon) * FIB_MULT;
        first = prod >> (32 - TABLE_BITS);
        idx = first;
        while (count_mem[idx] != 0 && key_mem[idx] != canon[KMER_W-1:0]) begin
            idx = (idx + 1) % SLOTS;
            if (idx == first) break;
        end
        r.is_new = 0;
        r.full = 0;
        if (count_mem[idx] == 0) begin
            key_mem[idx] = canon[KMER_W-1:0];
            count_mem[idx] = 1;
            r.count = 1;
            r.is_new = 1;
            if (distinct_seen < DIST_MAX) distinct_seen = distinct_seen + 1;
        end else if (key_mem[idx] == canon[KMER_W-1:0]) begin
            if (count_mem[idx] != COUNT_MAX) count_mem[idx] = count_mem[idx] + 1;
            r.count = count_mem[idx];
        end else begin
            r.full = 1;
            idx = first;
            r.count = 0;
        end
        r.kmer = canon[KMER_W-1:0];
        r.slot = idx[SLOT_OUT_W-1:0];
        r.distinct = distinct_seen;
        pending_counts.push_back(r);
    endtask

    // one input transaction; start stays high until the next item or a gap
    task automatic send_base(input logic [7:0] ch, input logic rs);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_base_char  <= ch;
        i_read_start <= rs;
        do @(posedge i_clk); while (busy);
        predict_count(ch, rs);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_kmer_length(input logic [K_W-1:0] k);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        k_reg = k;
    endtask

    function automatic logic [7:0] random_base();
        logic [7:0] ch;
        case ($urandom_range(3))
            0: ch = 8'h41;
            1: ch = 8'h43;
            2: ch = 8'h47;
            default: ch = 8'h54;
        endcase
        if ($urandom_range(1)) ch = ch | 8'h20;
        return ch;
    endfunction

    task automatic send_string(input string s, input logic rs_first);
        for (int i = 0; i < s.len(); i++) send_base(s[i], rs_first && i == 0);
    endtask

    task automatic test_directed_extremes();
        idle_pct = 0;
        // default k=15, mixed case and palindromic stretches
        send_string("ACGTacgtACGTacgTTGCA", 1'b1);
        send_base(8'h00, 1'b0);
        send_string("aaaa", 1'b0);
        send_base(8'hFF, 1'b0);
        send_base(8'h4E, 1'b1);
        write_kmer_length(5'd1);
        send_string("AaCcGgTt", 1'b1);
        send_string("AC", 1'b1);
    endtask

    task automatic test_length_changes();
        idle_pct = 0;
        write_kmer_length(5'd31);
        for (int i = 0; i < 40; i++) send_base(random_base(), i == 0);
        send_base(8'h54, 1'b1);
        for (int i = 0; i < 34; i++) send_base(8'h54, 1'b0);
        // shrink k mid-run: rolling values get masked, run counter kept
        write_kmer_length(5'd4);
        send_string("GATTACA", 1'b0);
        // zero acts as one
        write_kmer_length(5'd0);
        send_string("GTca", 1'b0);
        write_kmer_length(5'd9);
        send_string("CCGGAATT", 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [K_W-1:0] ks [6] = '{5'd3, 5'd31, 5'd1, 5'd12, 5'd0, 5'd6};
        int             pcts [3] = '{34, 51, 0};
        int             n;
        logic [7:0]     ch;
        for (int ph = 0; ph < 6; ph++) begin
            write_kmer_length(ks[ph]);
            idle_pct = pcts[ph % 3];
            n = 0;
            while (n < 165) begin
                case ($urandom_range(99)) inside
                    [0:5]:   ch = 8'($urandom_range(255));
                    default: ch = random_base();
                endcase
                send_base(ch, $urandom_range(99) < 3);
                n++;
            end
        end
    endtask

    task automatic test_repeated_kmers();
        idle_pct = 0;
        // k=2 leaves few distinct k-mers, so counts climb on known slots
        write_kmer_length(5'd2);
        for (int i = 0; i < 40; i++) send_base(random_base(), i == 0);
        send_base(8'h2E, 1'b1);
        send_string("ACGTACGTA", 1'b0);
    endtask

    // result checker: the receiver cannot stall, so every strobe is a transaction
    always @(posedge i_clk) begin
        t_count_result e;
        if (i_rst_n && o_valid) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected result kmer=%h", $time, o_kmer_value);
                errors++;
            end else begin
                e = pending_counts.pop_front();
                if (o_kmer_value !== e.kmer) begin
                    $display("%0t: kmer exp %h got %h", $time, e.kmer, o_kmer_value);
                    errors++;
                end
                if (o_slot_index !== e.slot) begin
                    $display("%0t: slot exp %0d got %0d", $time, e.slot, o_slot_index);
                    errors++;
                end
                if (o_kmer_count !== e.count) begin
                    $display("%0t: count exp %0d got %0d", $time, e.count, o_kmer_count);
                    errors++;
                end
                if (o_is_new !== e.is_new) begin
                    $display("%0t: is_new exp %b got %b", $time, e.is_new, o_is_new);
                    errors++;
                end
                if (o_table_full !== e.full) begin
                    $display("%0t: full exp %b got %b", $time, e.full, o_table_full);
                    errors++;
                end
                if (o_distinct_total !== e.distinct) begin
                    $display("%0t: distinct exp %0d got %0d", $time, e.distinct,
                             o_distinct_total);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        start = 0;
        i_base_char = 0;
        i_read_start = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        errors = 0;
        idle_pct = 0;
        stall_cycles = 0;
        k_reg = K_RESET;
        fwd_kmer = 0;
        rev_kmer = 0;
        run_len = 0;
        distinct_seen = 0;
        for (int i = 0; i < SLOTS; i++) begin
            key_mem[i] = '0;
            count_mem[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_length_changes();
        test_random_traffic();
        test_repeated_kmers();
        wait_quiet();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[sim.f]
sv/ckhc_pkg.sv
sv/ckhc_ram.sv
sv/ckhc_ctrl.sv
sv/ckhc_dp.sv
sv/canonical_kmer_hash_counter_top.sv
sim/tb_canonical_kmer_hash_counter_top.sv
